/* design/urxf_pkg.sv */
// shared types and constants for the uart receiver with receive ring fifo
`timescale 1ns / 1ps

package urxf_pkg;

    localparam int BYTE_W         = 8;
    localparam int PERIOD_W       = 16;
    localparam int BIT_IDX_W      = 3;
    localparam int FIFO_DEPTH_DEF = 64;
    localparam int IN_TDATA_W     = 8;
    localparam int OUT_TDATA_W    = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(104);

    typedef enum logic [1:0] {
        PHASE_IDLE  = 2'd0,
        PHASE_START = 2'd1,
        PHASE_DATA  = 2'd2
    } phase_t;

    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] data;
    } rx_result_t;

endpackage

/* design/uart_receiver_with_ring_fifo.sv */
// top level: uart 8n1 receiver feeding a ring fifo, with stream ports
`timescale 1ns / 1ps

// Each input item is one sampling tick carrying the rx line level and a pop
// request; each one yields exactly one output item. The receiver waits half a
// bit period after a falling edge, checks the start bit, then samples eight
// data bits lsb first one bit period apart; the stop bit is not checked. A
// completed byte is written to a ring fifo of FIFO_DEPTH slots that holds at
// most FIFO_DEPTH-1 bytes; a byte that finds it full is dropped and flagged as
// overflow. Push and pop in the same item both see the pointers from before
// that item. The block takes one item per clock while the output is not
// stalled: the fifo lives in a synchronous memory read on the accepting cycle,
// and the popped byte leaves through a two-stage pipeline (memory read stage,
// then output register); the item is captured in the memory read stage on the
// accepting edge and moves on when the output register is free or being
// drained. bit_period may be written at any time the block is idle and takes
// effect at the next countdown load.

module uart_receiver_with_ring_fifo #(
    parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // config register bit_period
    input  logic                           cfg_we,
    input  logic [urxf_pkg::PERIOD_W-1:0]  cfg_data,
    // input items
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [0] line_level, [1] pop_request, [7:2] zero
    input  logic [urxf_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // output items
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] read_data, [8] read_valid, [9] not_empty, [10] byte_received,
    // [11] overflow, [15:12] zero
    output logic [urxf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import urxf_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    // configuration
    logic [PERIOD_W-1:0] bit_period_reg;

    // fifo pointers
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] head_inc, tail_inc;

    // fifo storage, one write and one read port, registered read
    logic [BYTE_W-1:0] fifo_mem [FIFO_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // handshake and pipeline control
    logic accept;
    logic s1_move;
    logic line_level;
    logic pop_request;
    logic pop_ok;
    logic push_ok;
    logic push_drop;

    rx_result_t rx_res;

    // memory read stage
    logic s1_valid_reg;
    logic s1_rd_valid_reg;
    logic s1_not_empty_reg;
    logic s1_got_reg;
    logic s1_ovf_reg;

    // output register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    assign line_level  = s_axis_tdata[0];
    assign pop_request = s_axis_tdata[1];

    // pipeline advances when the output register is free or being drained
    assign s1_move       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    urxf_rx u_rx (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .level      (line_level),
        .bit_period (bit_period_reg),
        .result     (rx_res)
    );

    // ring wrap works for any depth, not only powers of two
    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);

    // both checks use the pointers from before this item
    assign pop_ok    = accept && pop_request && (head_reg != tail_reg);
    assign push_ok   = rx_res.done && (head_inc != tail_reg);
    assign push_drop = rx_res.done && (head_inc == tail_reg);

    assign head_next = push_ok ? head_inc : head_reg;
    assign tail_next = pop_ok  ? tail_inc : tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            bit_period_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // write at old head, read at old tail: distinct slots whenever both happen
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            fifo_mem[head_reg] <= rx_res.data;
        end
        if (pop_ok)
        begin
            rdata_reg <= fifo_mem[tail_reg];
        end
    end

    // memory read stage flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_valid_reg  <= pop_ok;
            s1_not_empty_reg <= (head_next != tail_next);
            s1_got_reg       <= push_ok;
            s1_ovf_reg       <= push_drop;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
        begin
            out_data_reg <= {
                (OUT_TDATA_W - BYTE_W - 4)'(0),
                s1_ovf_reg,
                s1_got_reg,
                s1_not_empty_reg,
                s1_rd_valid_reg,
                s1_rd_valid_reg ? rdata_reg : BYTE_W'(0)
            };
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* design/urxf_rx.sv */
// 8n1 receive sequencer: edge detect, start check and data bit sampling
`timescale 1ns / 1ps

module urxf_rx (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     level,
    input  logic [urxf_pkg::PERIOD_W-1:0] bit_period,
    output urxf_pkg::rx_result_t     result
);
    import urxf_pkg::*;

    phase_t                phase_reg, phase_next;
    logic                  prev_level_reg, prev_level_next;
    logic [PERIOD_W-1:0]   count_reg, count_next;
    logic [BIT_IDX_W-1:0]  bit_idx_reg, bit_idx_next;
    logic [BYTE_W-1:0]     shift_reg, shift_next;
    logic                  fires;
    logic [BYTE_W-1:0]     shift_with_bit;

    // countdown expires when it is at zero or one
    assign fires          = (count_reg <= PERIOD_W'(1));
    assign shift_with_bit = shift_reg | (BYTE_W'(level) << bit_idx_reg);

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        prev_level_next = prev_level_reg;
        count_next      = count_reg;
        bit_idx_next    = bit_idx_reg;
        shift_next      = shift_reg;
        if (step)
        begin
            prev_level_next = level;
            unique case (phase_reg)
                PHASE_START:
                begin
                    if (fires)
                    begin
                        count_next = '0;
                        if (!level)
                        begin
                            shift_next   = '0;
                            bit_idx_next = '0;
                            count_next   = bit_period;
                            phase_next   = PHASE_DATA;
                        end
                        else
                        begin
                            phase_next = PHASE_IDLE;
                        end
                    end
                    else
                    begin
                        count_next = count_reg - PERIOD_W'(1);
                    end
                end
                PHASE_DATA:
                begin
                    if (fires)
                    begin
                        count_next = '0;
                        shift_next = shift_with_bit;
                        if (bit_idx_reg == BIT_IDX_W'(BYTE_W - 1))
                        begin
                            bit_idx_next = '0;
                            phase_next   = PHASE_IDLE;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_reg + BIT_IDX_W'(1);
                            count_next   = bit_period;
                        end
                    end
                    else
                    begin
                        count_next = count_reg - PERIOD_W'(1);
                    end
                end
                default:
                begin
                    phase_next = PHASE_IDLE;
                    if (prev_level_reg && !level)
                    begin
                        count_next = bit_period >> 1;
                        phase_next = PHASE_START;
                    end
                end
            endcase
        end
    end

    // outputs: byte completes on the last data bit sample
    always_comb
    begin
        result.done = step && (phase_reg == PHASE_DATA) && fires
                      && (bit_idx_reg == BIT_IDX_W'(BYTE_W - 1));
        result.data = shift_with_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_IDLE;
            prev_level_reg <= 1'b1;
            count_reg      <= '0;
            bit_idx_reg    <= '0;
            shift_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            prev_level_reg <= prev_level_next;
            count_reg      <= count_next;
            bit_idx_reg    <= bit_idx_next;
            shift_reg      <= shift_next;
        end
    end

endmodule

/* dv/tb_uart_receiver_with_ring_fifo.sv */
// testbench for the uart 8n1 receiver with receive ring fifo
`timescale 1ns / 1ps

module tb_uart_receiver_with_ring_fifo;
    import urxf_pkg::*;

    localparam int FIFO_SLOTS  = FIFO_DEPTH_DEF;
    // limit lies far above the slowest run here
    localparam int CYCLE_LIMIT = 100_000;

    // output item fields, lowest bits last so the cast matches m_axis_tdata[11:0]
    typedef struct packed {
        logic              overflow;
        logic              byte_received;
        logic              not_empty;
        logic              read_valid;
        logic [BYTE_W-1:0] read_data;
    } rx_out_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [PERIOD_W-1:0]    cfg_data = PERIOD_RESET;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [0] line_level, [1] pop_request, [7:2] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [7:0] read_data, [8] read_valid, [9] not_empty, [10] byte_received,
    // [11] overflow, [15:12] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // ticks waiting to be driven, {pop_request, line_level}
    logic [1:0]  line_tick_q[$];
    // predicted output items, oldest first
    rx_out_t     predicted_rx_q[$];

    int          items_queued = 0;
    int          results_seen = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    // predictor state: receiver, fifo and the shadow of bit_period
    logic                line_prev = 1'b1;
    phase_t              rx_phase = PHASE_IDLE;
    logic [PERIOD_W-1:0] countdown = '0;
    logic [2:0]          bit_pos = '0;
    logic [BYTE_W-1:0]   shift_reg = '0;
    logic [BYTE_W-1:0]   fifo_mem [FIFO_SLOTS];
    int unsigned         wr_ptr = 0;
    int unsigned         rd_ptr = 0;
    logic [PERIOD_W-1:0] period_shadow = PERIOD_RESET;

    rx_out_t             want_out;
    rx_out_t             seen_out;

    uart_receiver_with_ring_fifo #(
        .FIFO_DEPTH    (FIFO_SLOTS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // countdown step: true on the tick it expires, a load of 0 or 1 expires next tick
    function automatic logic tick_expired();
        if (countdown <= 1)
        begin
            countdown = '0;
            return 1'b1;
        end
        countdown = countdown - 1'b1;
        return 1'b0;
    endfunction

    // one sampling tick of the receiver and fifo, returns the output item it yields
    function automatic rx_out_t next_rx_outputs(input logic level, input logic pop_req);
        int unsigned head_now;
        int unsigned tail_now;
        int unsigned head_next;
        int unsigned tail_next;
        logic        done;
        logic [7:0]  done_byte;
        rx_out_t     r;
        head_now  = wr_ptr;
        tail_now  = rd_ptr;
        done      = 1'b0;
        done_byte = '0;
        r         = '0;
        case (rx_phase)
            PHASE_START:
            begin
                if (tick_expired())
                begin
                    // start bit still low at mid bit: go for the data bits
                    if (!level)
                    begin
                        shift_reg = '0;
                        bit_pos   = '0;
                        countdown = period_shadow;
                        rx_phase  = PHASE_DATA;
                    end
                    else
                    begin
                        rx_phase = PHASE_IDLE;
                    end
                end
            end
            PHASE_DATA:
            begin
                if (tick_expired())
                begin
                    shift_reg = shift_reg | (8'(level) << bit_pos);
                    if (bit_pos == 3'd7)
                    begin
                        done      = 1'b1;
                        done_byte = shift_reg;
                        bit_pos   = '0;
                        rx_phase  = PHASE_IDLE;
                    end
                    else
                    begin
                        bit_pos   = bit_pos + 1'b1;
                        countdown = period_shadow;
                    end
                end
            end
            default:
            begin
                // edges only count while idle
                rx_phase = PHASE_IDLE;
                if (line_prev && !level)
                begin
                    countdown = period_shadow >> 1;
                    rx_phase  = PHASE_START;
                end
            end
        endcase
        line_prev = level;

        // pop and push both see the pointers from the start of the tick
        tail_next = tail_now;
        if (pop_req && head_now != tail_now)
        begin
            r.read_data  = fifo_mem[tail_now];
            r.read_valid = 1'b1;
            tail_next    = (tail_now + 1) % FIFO_SLOTS;
        end
        head_next = head_now;
        if (done)
        begin
            if ((head_now + 1) % FIFO_SLOTS != tail_now)
            begin
                fifo_mem[head_now] = done_byte;
                head_next          = (head_now + 1) % FIFO_SLOTS;
                r.byte_received    = 1'b1;
            end
            else
            begin
                r.overflow = 1'b1;
            end
        end
        wr_ptr      = head_next;
        rd_ptr      = tail_next;
        r.not_empty = (head_next != tail_next);
        return r;
    endfunction

    task automatic check_field(input string fname, input int want, input int seen);
        if (want != seen)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want,
                     seen);
            fail_count++;
        end
    endtask

    // driver: next tick goes out once the current one is taken, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (line_tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_TDATA_W'(line_tick_q.pop_front());
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: predict on each accepted input item, then check each accepted output item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            line_prev     = 1'b1;
            rx_phase      = PHASE_IDLE;
            countdown     = '0;
            bit_pos       = '0;
            shift_reg     = '0;
            wr_ptr        = 0;
            rd_ptr        = 0;
            period_shadow = PERIOD_RESET;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted_rx_q.push_back(next_rx_outputs(s_axis_tdata[0], s_axis_tdata[1]));
            end
            // a write takes effect for items after this edge
            if (cfg_we)
            begin
                period_shadow = cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_out = rx_out_t'(m_axis_tdata[11:0]);
                if (predicted_rx_q.size() == 0)
                begin
                    $display("%0t ns: output item with none expected, expected none, actual %h",
                             $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want_out = predicted_rx_q.pop_front();
                    check_field("read_data", want_out.read_data, seen_out.read_data);
                    check_field("read_valid", want_out.read_valid, seen_out.read_valid);
                    check_field("not_empty", want_out.not_empty, seen_out.not_empty);
                    check_field("byte_received", want_out.byte_received,
                                seen_out.byte_received);
                    check_field("overflow", want_out.overflow, seen_out.overflow);
                end
                results_seen++;
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic push_tick(input logic level, input logic pop_req);
        line_tick_q.push_back({pop_req, level});
        items_queued++;
    endtask

    // well-formed 8n1 frame: start bit, eight data bits lsb first, stop bit
    task automatic send_frame(input logic [7:0] data_byte, input int bit_len,
                              input int pop_pct);
        repeat (bit_len) push_tick(1'b0, chance(pop_pct));
        for (int k = 0; k < 8; k++)
        begin
            repeat (bit_len) push_tick(data_byte[k], chance(pop_pct));
        end
        repeat (bit_len) push_tick(1'b1, chance(pop_pct));
    endtask

    // mostly good frames, some glitches shorter than the start check, some line noise
    task automatic send_mix(input int frames, input int bit_len, input int pop_pct);
        int kind;
        int half;
        half = bit_len / 2;
        for (int f = 0; f < frames; f++)
        begin
            kind = $urandom_range(99);
            if (kind < 75)
            begin
                send_frame(8'($urandom_range(255)), bit_len, pop_pct);
            end
            else if (kind < 87)
            begin
                // line back high by the time the start bit is checked
                repeat ((half < 1) ? 1 : $urandom_range(half, 1))
                    push_tick(1'b0, chance(pop_pct));
                repeat (bit_len + 1) push_tick(1'b1, chance(pop_pct));
            end
            else
            begin
                repeat ($urandom_range(3 * bit_len, 1))
                    push_tick(1'($urandom_range(1)), chance(pop_pct));
                repeat (10 * bit_len + 2) push_tick(1'b1, chance(pop_pct));
            end
            repeat ($urandom_range(3)) push_tick(1'b1, chance(pop_pct));
        end
        // let any frame in progress finish before the next setting
        repeat (10 * bit_len + 2) push_tick(1'b1, chance(pop_pct));
    endtask

    // every item yields one output item, so all done means the counts match
    task automatic drain();
        while (results_seen != items_queued) @(posedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] period);
        drain();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= period;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [7:0] slow_byte;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset bit period: short low pulse rejected at the start check
        push_tick(1'b1, 1'b0);
        repeat (3) push_tick(1'b0, 1'b0);
        repeat (56) push_tick(1'b1, chance(20));

        // directed: shortest legal bit period
        write_period(16'd2);
        push_tick(1'b1, 1'b1);              // pop on empty fifo
        send_frame(8'hFF, 2, 100);          // pop in the completing tick misses the byte
        push_tick(1'b0, 1'b0);              // glitch rejected at the start check
        push_tick(1'b1, 1'b0);

        // let bytes pile up in the fifo with occasional pops
        send_mix(6, 2, 20);

        // sender idle most cycles
        send_idle_pct = 86;
        write_period(16'd2);
        send_mix(3, 2, 50);

        // receiver stalling most cycles
        send_idle_pct = 0;
        stall_pct     = 86;
        write_period(16'd2);
        send_mix(3, 2, 50);

        // both sides idling now and then
        send_idle_pct = 16;
        stall_pct     = 16;
        write_period(16'd3);
        send_mix(3, 3, 50);

        // bit periods below the legal range collapse every wait to one tick
        send_idle_pct = 0;
        stall_pct     = 0;
        write_period(16'd1);
        send_mix(3, 1, 50);
        write_period(16'd0);
        send_mix(3, 1, 50);

        // start edge, then shorten the period during the start check;
        // the running half-period wait stays, the data bits use the new period
        slow_byte = 8'($urandom_range(255));
        write_period(16'd40);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b1);
        repeat (4) push_tick(1'b0, chance(30));
        write_period(16'd3);
        repeat (17) push_tick(1'b0, chance(30));
        for (int k = 0; k < 8; k++)
        begin
            repeat (3) push_tick(slow_byte[k], chance(30));
        end
        repeat (20) push_tick(1'b1, chance(30));

        // last mixed stretch with light idling on both sides
        send_idle_pct = 16;
        stall_pct     = 16;
        write_period(16'd3);
        send_mix(2, 3, 40);

        drain();
        // catch any stray output item after the last expected one
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
